>>> sv/smap_pkg.sv
// Shared types and constants of the stick calibration mapper.
`default_nettype none

package smap_pkg;

   // Item kinds carried on the request channel.
   localparam logic [1:0] KIND_START   = 2'd0;
   localparam logic [1:0] KIND_CENTRE  = 2'd1;
   localparam logic [1:0] KIND_RANGE   = 2'd2;
   localparam logic [1:0] KIND_CONVERT = 2'd3;

   // Axis numbering; the throttle axis uses a single inverted span.
   localparam logic [1:0] THROTTLE_AXIS = 2'd2;
   localparam int         NUM_AXES      = 4;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_OUT_LOW  = 2'd0;
   localparam logic [1:0] CSR_OUT_MID  = 2'd1;
   localparam logic [1:0] CSR_OUT_HIGH = 2'd2;
   localparam logic [1:0] CSR_REVERSE  = 2'd3;

   // Output scale.
   localparam int              OUT_WIDTH      = 13;
   localparam int              FULL_SCALE_INT = 8191;
   localparam logic [12:0]     FULL_SCALE     = 13'd8191;
   localparam int              RESET_CENTRE   = 988;
   localparam logic [12:0]     RESET_OUT_LOW  = 13'd0;
   localparam logic [12:0]     RESET_OUT_MID  = 13'd4095;
   localparam logic [12:0]     RESET_OUT_HIGH = 13'd8191;

   // Magnitude of an output span (out_mid + 1 may reach 8192).
   localparam int SPAN_WIDTH = 14;

   // Widest sample the design supports; the request port carries 13 bits.
   localparam int MAX_SAMPLE_WIDTH = 16;
   localparam int REQ_SAMPLE_WIDTH = 13;

   // Calibration update sent to the point store.
   typedef struct packed {
      logic       en;
      logic [1:0] kind;
      logic [1:0] axis;
   } smap_cal_cmd_type;

endpackage

`default_nettype wire

>>> sv/smap_cal_store.sv
// Low, centre and high calibration points of the four axes.
`default_nettype none

module smap_cal_store #(
   parameter int SAMPLE_WIDTH = 13,
   parameter int EDGE_CUTOFF  = 0
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire smap_pkg::smap_cal_cmd_type cmd,
   input  wire [SAMPLE_WIDTH-1:0]          cmd_sample,
   input  wire [1:0]                       rd_axis,
   output logic [SAMPLE_WIDTH-1:0]         rd_low,
   output logic [SAMPLE_WIDTH-1:0]         rd_centre,
   output logic [SAMPLE_WIDTH-1:0]         rd_high
);
   import smap_pkg::*;

   localparam logic [SAMPLE_WIDTH-1:0] LOW_RESET    = SAMPLE_WIDTH'(EDGE_CUTOFF);
   localparam logic [SAMPLE_WIDTH-1:0] HIGH_RESET   =
      SAMPLE_WIDTH'(FULL_SCALE_INT - EDGE_CUTOFF);
   localparam logic [SAMPLE_WIDTH-1:0] CENTRE_RESET = SAMPLE_WIDTH'(RESET_CENTRE);
   localparam logic [SAMPLE_WIDTH-1:0] MID_POINT    =
      SAMPLE_WIDTH'((FULL_SCALE_INT - 2 * EDGE_CUTOFF) / 2);

   logic [SAMPLE_WIDTH-1:0] low_ff    [NUM_AXES];
   logic [SAMPLE_WIDTH-1:0] high_ff   [NUM_AXES];
   logic [SAMPLE_WIDTH-1:0] centre_ff [NUM_AXES];
   logic [SAMPLE_WIDTH-1:0] low_in    [NUM_AXES];
   logic [SAMPLE_WIDTH-1:0] high_in   [NUM_AXES];
   logic [SAMPLE_WIDTH-1:0] centre_in [NUM_AXES];

   // Apply one calibration command to every entry it touches.
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         low_in[i]    = low_ff[i];
         high_in[i]   = high_ff[i];
         centre_in[i] = centre_ff[i];
         if (cmd.en) begin
            case (cmd.kind)
               KIND_START: begin
                  low_in[i]    = MID_POINT;
                  high_in[i]   = MID_POINT;
                  centre_in[i] = MID_POINT;
               end
               KIND_CENTRE: begin
                  if (cmd.axis == 2'(i) && cmd.axis != THROTTLE_AXIS) begin
                     centre_in[i] = cmd_sample;
                  end
               end
               KIND_RANGE: begin
                  if (cmd.axis == 2'(i)) begin
                     if (cmd_sample < low_ff[i]) begin
                        low_in[i] = cmd_sample;
                     end
                     if (cmd_sample > high_ff[i]) begin
                        high_in[i] = cmd_sample;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_AXES; i++) begin
         if (reset) begin
            low_ff[i]    <= LOW_RESET;
            high_ff[i]   <= HIGH_RESET;
            centre_ff[i] <= CENTRE_RESET;
         end else begin
            low_ff[i]    <= low_in[i];
            high_ff[i]   <= high_in[i];
            centre_ff[i] <= centre_in[i];
         end
      end
   end

   // Points of the axis being converted.
   assign rd_low    = low_ff[rd_axis];
   assign rd_centre = centre_ff[rd_axis];
   assign rd_high   = high_ff[rd_axis];

endmodule

`default_nettype wire

>>> sv/smap_serial_mul.sv
// Shift-and-add multiplier that retires one multiplier bit per cycle.
`default_nettype none

module smap_serial_mul #(
   parameter int SAMPLE_WIDTH = 13
) (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire                                          start,
   input  wire [SAMPLE_WIDTH-1:0]                       multiplicand,
   input  wire [smap_pkg::SPAN_WIDTH-1:0]               multiplier,
   output logic                                         done,
   output logic [SAMPLE_WIDTH+smap_pkg::SPAN_WIDTH-1:0] product
);
   import smap_pkg::*;

   localparam int CW = $clog2(SPAN_WIDTH);
   localparam logic [CW-1:0] LAST_STEP = CW'(SPAN_WIDTH - 1);

   logic [SAMPLE_WIDTH-1:0] hi_ff;
   logic [SPAN_WIDTH-1:0]   lo_ff;
   logic [SAMPLE_WIDTH-1:0] mcand_ff;
   logic [CW-1:0]           cnt_ff;
   logic                    busy_ff;
   logic                    done_ff;
   logic [SAMPLE_WIDTH:0]   partial;

   // Add the multiplicand into the high half when the low bit is set.
   assign partial = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && cnt_ff == LAST_STEP;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Product shift register: the partial sum enters at the top.
   always_ff @(posedge clock) begin
      if (start) begin
         hi_ff    <= '0;
         lo_ff    <= multiplier;
         mcand_ff <= multiplicand;
      end else if (busy_ff) begin
         {hi_ff, lo_ff} <= {partial, lo_ff[SPAN_WIDTH-1:1]};
      end
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

`default_nettype wire

>>> sv/smap_serial_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module smap_serial_div #(
   parameter int SAMPLE_WIDTH = 13
) (
   input  wire                                          clock,
   input  wire                                          reset,
   input  wire                                          start,
   input  wire [SAMPLE_WIDTH+smap_pkg::SPAN_WIDTH-1:0]  dividend,
   input  wire [SAMPLE_WIDTH-1:0]                       divisor,
   output logic                                         done,
   output logic [SAMPLE_WIDTH+smap_pkg::SPAN_WIDTH-1:0] quotient
);
   import smap_pkg::*;

   localparam int PW = SAMPLE_WIDTH + SPAN_WIDTH;
   localparam int CW = $clog2(PW);
   localparam logic [CW-1:0] LAST_STEP = CW'(PW - 1);

   logic [SAMPLE_WIDTH-1:0] rem_ff;
   logic [PW-1:0]           quo_ff;
   logic [SAMPLE_WIDTH-1:0] dvs_ff;
   logic [CW-1:0]           cnt_ff;
   logic                    busy_ff;
   logic                    done_ff;
   logic [SAMPLE_WIDTH:0]   trial;
   logic [SAMPLE_WIDTH+1:0] diff;

   // Bring down the next dividend bit and try the subtraction.
   assign trial = {rem_ff, quo_ff[PW-1]};
   assign diff  = {1'b0, trial} - {2'b00, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && cnt_ff == LAST_STEP;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Remainder and quotient shift left together; a borrow restores.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         if (!diff[SAMPLE_WIDTH+1]) begin
            rem_ff <= diff[SAMPLE_WIDTH-1:0];
            quo_ff <= {quo_ff[PW-2:0], 1'b1};
         end else begin
            rem_ff <= trial[SAMPLE_WIDTH-1:0];
            quo_ff <= {quo_ff[PW-2:0], 1'b0};
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> sv/stick_calibration_mapper.sv
// Top level of the four-axis stick calibration mapper.
//
//  Channel   Ports                                        Direction
//  request   req_valid/req_ready, kind, axis, sample      in
//  response  rsp_valid/rsp_ready, value, valid_res        out
//  settings  csr_we, csr_index, csr_wdata                 in, write only
//
// One item is in work at a time. A calibration item passes through the
// execute and done states, and the next request is taken once its
// response is loaded. A convert item runs the bit-serial multiplier (14
// steps) and then the bit-serial divider (SAMPLE_WIDTH + 14 steps) before
// its result is finished; the next request is taken once the response is
// loaded. A zero input span skips both. Reset is synchronous and restores
// the state, the response valid flag, the settings registers and all
// calibration points. The response register holds a finished result while
// the next request is taken; a stalled response delays only the completion
// of the following item.
`default_nettype none

module stick_calibration_mapper #(
   parameter int SAMPLE_WIDTH = 13,
   parameter int EDGE_CUTOFF  = 0
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [1:0]  req_kind,
   input  wire  [1:0]  req_axis,
   input  wire  [12:0] req_sample,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [12:0] rsp_value,
   output logic        rsp_valid_res,
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [12:0] csr_wdata
);
   import smap_pkg::*;

   localparam int SW = SAMPLE_WIDTH;
   localparam int PW = SW + SPAN_WIDTH;
   localparam int VW = PW + 2;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_MULT = 3'd2;
   localparam logic [2:0] ST_DIVD = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]  state_ff, state_in;

   // Settings registers.
   logic [12:0] out_low_ff, out_mid_ff, out_high_ff;
   logic [3:0]  reverse_ff;

   // Request held while it is worked on.
   logic [1:0]  kind_ff, axis_ff;
   logic [SW-1:0] sample_ff;
   logic [MAX_SAMPLE_WIDTH-1:0] sample_wide;

   // Operands of the division and the final offset.
   logic [SW-1:0]         div_mag_ff, div_mag_in;
   logic                  neg_ff, neg_in;
   logic                  zero_ff, zero_in;
   logic [SPAN_WIDTH-1:0] base_ff, base_in;

   // Result waiting for the response register.
   logic [12:0] res_value_ff, res_value_in;
   logic        res_flag_ff, res_flag_in;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [12:0] rsp_value_ff, rsp_value_in;
   logic        rsp_flag_ff, rsp_flag_in;

   logic [SW-1:0]         rd_low, rd_centre, rd_high;
   logic [SW-1:0]         seg_a, seg_b;
   logic [SPAN_WIDTH-1:0] seg_c;
   logic [12:0]           seg_d;
   logic [SW:0]           diff_xa, diff_ba;
   logic [SPAN_WIDTH:0]   diff_dc;
   logic [SW-1:0]         mag_xa;
   logic [SPAN_WIDTH-1:0] mag_dc;
   logic                  req_xfer, is_convert, slot_free;
   logic                  mul_start, mul_done, div_start, div_done;
   logic [PW-1:0]         product, quotient, q_mag;
   logic signed [VW-1:0]  v_sum, v_low, v_high;
   logic [12:0]           clamped, final_value;
   smap_cal_cmd_type      cal_cmd;

   assign req_xfer   = req_valid && req_ready;
   assign req_ready  = state_ff == ST_IDLE;
   assign is_convert = kind_ff == KIND_CONVERT;
   assign slot_free  = !rsp_valid_ff || rsp_ready;

   // Only the low SAMPLE_WIDTH bits of a reading are used.
   assign sample_wide = MAX_SAMPLE_WIDTH'(req_sample);

   // Settings writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_low_ff  <= RESET_OUT_LOW;
         out_mid_ff  <= RESET_OUT_MID;
         out_high_ff <= RESET_OUT_HIGH;
         reverse_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OUT_LOW:  out_low_ff  <= csr_wdata;
            CSR_OUT_MID:  out_mid_ff  <= csr_wdata;
            CSR_OUT_HIGH: out_high_ff <= csr_wdata;
            CSR_REVERSE:  reverse_ff  <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // Capture the request on transfer.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         kind_ff   <= req_kind;
         axis_ff   <= req_axis;
         sample_ff <= sample_wide[SW-1:0];
      end
   end

   // Calibration updates take effect in the execute cycle.
   assign cal_cmd.en   = state_ff == ST_EXEC && !is_convert;
   assign cal_cmd.kind = kind_ff;
   assign cal_cmd.axis = axis_ff;

   smap_cal_store #(
      .SAMPLE_WIDTH (SW),
      .EDGE_CUTOFF  (EDGE_CUTOFF)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cal_cmd),
      .cmd_sample (sample_ff),
      .rd_axis    (axis_ff),
      .rd_low     (rd_low),
      .rd_centre  (rd_centre),
      .rd_high    (rd_high)
   );

   // Pick the segment of the curve that the sample falls on.
   always_comb begin
      if (axis_ff == THROTTLE_AXIS) begin
         seg_a = rd_high;
         seg_b = rd_low;
         seg_c = {1'b0, out_low_ff};
         seg_d = out_high_ff;
      end else if (sample_ff <= rd_centre) begin
         seg_a = rd_low;
         seg_b = rd_centre;
         seg_c = {1'b0, out_low_ff};
         seg_d = out_mid_ff;
      end else begin
         seg_a = rd_centre;
         seg_b = rd_high;
         seg_c = {1'b0, out_mid_ff} + SPAN_WIDTH'(1);
         seg_d = out_high_ff;
      end
   end

   // Signed differences, split into sign and magnitude.
   assign diff_xa = {1'b0, sample_ff} - {1'b0, seg_a};
   assign diff_ba = {1'b0, seg_b} - {1'b0, seg_a};
   assign diff_dc = {2'b00, seg_d} - {1'b0, seg_c};
   assign mag_xa  = diff_xa[SW] ? SW'(-diff_xa) : diff_xa[SW-1:0];
   assign mag_dc  = diff_dc[SPAN_WIDTH] ? SPAN_WIDTH'(-diff_dc) : diff_dc[SPAN_WIDTH-1:0];

   assign div_mag_in = diff_ba[SW] ? SW'(-diff_ba) : diff_ba[SW-1:0];
   assign neg_in     = diff_xa[SW] ^ diff_ba[SW] ^ diff_dc[SPAN_WIDTH];
   assign zero_in    = diff_ba == '0;
   assign base_in    = seg_c;

   always_ff @(posedge clock) begin
      if (state_ff == ST_EXEC) begin
         div_mag_ff <= div_mag_in;
         neg_ff     <= neg_in;
         zero_ff    <= zero_in;
         base_ff    <= base_in;
      end
   end

   assign mul_start = state_ff == ST_EXEC && is_convert && !zero_in;
   assign div_start = state_ff == ST_MULT && mul_done;

   smap_serial_mul #(
      .SAMPLE_WIDTH (SW)
   ) u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (mag_xa),
      .multiplier   (mag_dc),
      .done         (mul_done),
      .product      (product)
   );

   smap_serial_div #(
      .SAMPLE_WIDTH (SW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (div_mag_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // Offset by the segment's low output, clamp, then reverse if asked.
   assign q_mag  = zero_ff ? '0 : quotient;
   assign v_sum  = neg_ff ? $signed(VW'(base_ff)) - $signed(VW'(q_mag))
                          : $signed(VW'(base_ff)) + $signed(VW'(q_mag));
   assign v_low  = $signed(VW'(out_low_ff));
   assign v_high = $signed(VW'(out_high_ff));

   always_comb begin
      if (v_sum < v_low) begin
         clamped = out_low_ff;
      end else if (v_sum > v_high) begin
         clamped = out_high_ff;
      end else begin
         clamped = v_sum[12:0];
      end
      final_value = reverse_ff[axis_ff] ? FULL_SCALE - clamped : clamped;
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      res_value_in = res_value_ff;
      res_flag_in  = res_flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_flag_in  = rsp_flag_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!is_convert) begin
               res_value_in = '0;
               res_flag_in  = 1'b0;
               state_in     = ST_DONE;
            end else if (zero_in) begin
               state_in = ST_FIN;
            end else begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            if (mul_done) begin
               state_in = ST_DIVD;
            end
         end
         ST_DIVD: begin
            if (div_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            res_value_in = final_value;
            res_flag_in  = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_value_ff;
               rsp_flag_in  = res_flag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_value_ff <= res_value_in;
      res_flag_ff  <= res_flag_in;
      rsp_value_ff <= rsp_value_in;
      rsp_flag_ff  <= rsp_flag_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value     = rsp_value_ff;
   assign rsp_valid_res = rsp_flag_ff;

endmodule

`default_nettype wire

>>> sv/smap_checker.sv
// Port-level checks of the stick calibration mapper and their binding.
`default_nettype none

module smap_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [12:0] rsp_value,
   input wire        rsp_valid_res
);

   // A response that is not taken stays put.
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(rsp_value) && $stable(rsp_valid_res);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold)
      else $error("response changed while stalled");

   // Calibration responses carry a zero value.
   property p_zero_value;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_valid_res |-> rsp_value == 13'd0;
   endproperty
   a_zero_value: assert property (p_zero_value)
      else $error("non-convert response with a non-zero value");

   // After a request transfer the block is busy with that item.
   property p_one_in_flight;
      @(posedge clock) disable iff (reset)
         req_valid && req_ready |=> !req_ready;
   endproperty
   a_one_in_flight: assert property (p_one_in_flight)
      else $error("request taken while an item is in work");

   // Reset leaves an empty response register and an idle block.
   property p_reset_state;
      @(posedge clock) reset |=> !rsp_valid && req_ready;
   endproperty
   a_reset_state: assert property (p_reset_state)
      else $error("block not idle after reset");

endmodule

bind stick_calibration_mapper smap_checker u_smap_checker (.*);

`default_nettype wire
